// File: src/svf_pkg.sv
// Shared types, constants and arithmetic helpers of the multimode state-variable filter.
// No dependencies; every other file of the filter depends on this package.
`timescale 1ns / 1ps
package svf_pkg;

  localparam int CHANNELS_DEF   = 2;
  localparam int TANH_SIZE_DEF  = 64;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 24;
  localparam int STATE_W  = 32;
  localparam int ACC_W    = 52;
  localparam int MUL_A_W  = 35;
  localparam int MUL_B_W  = 27;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ROM_W    = 27;
  localparam int POS_W    = 42;
  localparam int MAG_W    = 34;
  localparam int CFG_IDX_W = 3;

  // Drive gains in Q2.16 for the mild and strong characters.
  localparam logic [17:0] GAIN_X_MILD   = 18'd131072;
  localparam logic [17:0] GAIN_D_MILD   = 18'd22938;
  localparam logic [17:0] GAIN_X_STRONG = 18'd163840;
  localparam logic [17:0] GAIN_D_STRONG = 18'd49152;

  localparam logic [ROM_W-1:0] Q26_ONE = ROM_W'(1) << 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_CHARACTER = 3'd1,
    REG_RESPONSE  = 3'd2,
    REG_STEEP     = 3'd3,
    REG_DAMPING   = 3'd4,
    REG_GAIN_A1   = 3'd5,
    REG_GAIN_A2   = 3'd6,
    REG_GAIN_A3   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CHR_CLEAN0 = 3'd0,
    CHR_CLEAN1 = 3'd1,
    CHR_TWO    = 3'd2,
    CHR_MILD   = 3'd3,
    CHR_STRONG = 3'd4
  } character_t;

  typedef enum logic [1:0] {
    RESP_LOW  = 2'd0,
    RESP_BAND = 2'd1,
    RESP_HIGH = 2'd2
  } response_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DRV1,
    ST_DRV2,
    ST_DRV3,
    ST_DRV4,
    ST_DRV5,
    ST_V3,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_F5,
    ST_WB
  } state_t;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sh0000_7FFF_FFFF;
    lo = -48'sh0000_8000_0000;
    if (v > hi) return hi[STATE_W-1:0];
    else if (v < lo) return lo[STATE_W-1:0];
    else return v[STATE_W-1:0];
  endfunction

  // Q5.26 to Q1.23: divide by eight, round half up, saturate.
  function automatic logic signed [SAMPLE_W-1:0] to_q123(input logic signed [STATE_W-1:0] v);
    logic signed [STATE_W:0] t;
    t = ($signed({v[STATE_W-1], v}) + 33'sd4) >>> 3;
    if (t > 33'sd8388607) return 24'sh7FFFFF;
    else if (t < -33'sd8388608) return 24'sh800000;
    else return t[SAMPLE_W-1:0];
  endfunction

endpackage

// File: src/svf_if.sv
// Handshake interfaces of the multimode state-variable filter: sample in, sample out, config.
// Depends on svf_pkg for field widths.
`timescale 1ns / 1ps
interface svf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [svf_pkg::SAMPLE_W-1:0] sample_in;
  logic                                chan;
  modport source (output valid, output sample_in, output chan, input ready);
  modport sink (input valid, input sample_in, input chan, output ready);
endinterface

interface svf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svf_pkg::SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface svf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [svf_pkg::CFG_IDX_W-1:0]        index;
  logic [svf_pkg::COEF_W-1:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/svf_mul.sv
// Shared signed multiplier of the filter with a registered product.
// Depends on svf_pkg for operand widths.
`timescale 1ns / 1ps
module svf_mul (
  input  logic                                clk,
  input  logic signed [svf_pkg::MUL_A_W-1:0]  a,
  input  logic signed [svf_pkg::MUL_B_W-1:0]  b,
  output logic signed [svf_pkg::PROD_W-1:0]   prod
);
  import svf_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// File: src/svf_tanh.sv
// Tanh table lookup: splits a table position into index and fraction and reads two entries.
// Depends on svf_pkg; the table is built at elaboration from TANH_TABLE_SIZE.
`timescale 1ns / 1ps
module svf_tanh #(
  parameter int TANH_TABLE_SIZE = svf_pkg::TANH_SIZE_DEF
) (
  input  logic [svf_pkg::POS_W-1:0]  pos,
  output logic [svf_pkg::ROM_W-1:0]  base,
  output logic [svf_pkg::ROM_W-1:0]  slope,
  output logic [25:0]                frac,
  output logic                       full
);
  import svf_pkg::*;

  localparam int IW = $clog2(TANH_TABLE_SIZE + 1);
  localparam longint Q30 = longint'(1) << 30;
  localparam longint INV_E_Q30 = 395007542;

  typedef logic [ROM_W-1:0] rom_t [0:TANH_TABLE_SIZE];

  // Long division of non-negative operands, used only while the table is built.
  function automatic longint div_pos(input longint num, input longint den);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] rem;
    n = 64'(num);
    d = 64'(den);
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem = rem - d;
        q[b] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  // tanh(4i/N) = (1 - z) / (1 + z) with z = exp(-8i/N) in Q30.
  function automatic rom_t build_rom();
    rom_t   r;
    longint y;
    longint n;
    longint f;
    longint sum;
    longint t;
    for (int i = 0; i <= TANH_TABLE_SIZE; i++) begin
      y = div_pos((longint'(8) * i) << 30, longint'(TANH_TABLE_SIZE));
      n = y >>> 30;
      f = y & (Q30 - 1);
      sum = Q30;
      t = Q30;
      for (int k = 1; k <= 20; k++) begin
        t = div_pos(t * f, longint'(k) << 30);
        sum = ((k & 1) != 0) ? sum - t : sum + t;
      end
      for (longint j = 0; j < n; j++) begin
        sum = (sum * INV_E_Q30) >>> 30;
      end
      r[i] = ROM_W'(div_pos((Q30 - sum) << 26, Q30 + sum));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [POS_W-27:0] idx;
  logic [IW-1:0]     idx_r;
  logic [ROM_W-1:0]  lo_v;
  logic [ROM_W-1:0]  hi_v;

  assign idx   = pos[POS_W-1:26];
  assign full  = idx >= (POS_W-26)'(TANH_TABLE_SIZE);
  assign idx_r = full ? '0 : idx[IW-1:0];
  assign lo_v  = ROM[idx_r];
  assign hi_v  = ROM[idx_r + IW'(1)];
  assign base  = lo_v;
  assign slope = (hi_v > lo_v) ? hi_v - lo_v : '0;
  assign frac  = pos[25:0];

endmodule

// File: src/multimode_svf_filter.sv
// Top level of the multimode state-variable filter: sequencer, state and shared datapath.
// Depends on svf_pkg, svf_if, svf_mul and svf_tanh.
`timescale 1ns / 1ps
// Two-channel trapezoidal state-variable filter built around one shared multiplier that a
// small sequencer steps through the stage equations. A filter stage runs through a state
// fetch, v3, five multiplies and a write-back, with the drive steps between fetch and v3
// when a drive character (3 or 4) soft-clips the stage input through the tanh table. An
// item is accepted, then runs through one or two stages on the single multiplier; when the
// filter is disabled the sample passes straight to the output register in the cycle it is
// accepted. The input is held not ready while an item is in work or while the output
// register holds a word not yet taken. Configuration writes are always taken and must only
// come while the filter is idle.
module multimode_svf_filter #(
  parameter int CHANNELS        = svf_pkg::CHANNELS_DEF,
  parameter int TANH_TABLE_SIZE = svf_pkg::TANH_SIZE_DEF
) (
  input logic      clk,
  input logic      rst,
  svf_in_if.sink   din,
  svf_out_if.source dout,
  svf_cfg_if.sink  cfg
);
  import svf_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOTS = 2 * CHANNELS;

  // Configuration registers.
  logic              enable;
  logic [2:0]        character;
  logic [1:0]        response;
  logic              steep_slope;
  logic [COEF_W-1:0] damping_coef;
  logic [COEF_W-1:0] gain_a1;
  logic [COEF_W-1:0] gain_a2;
  logic [COEF_W-1:0] gain_a3;

  state_t state, state_next;

  logic signed [STATE_W-1:0]  integrator_one [0:SLOTS-1];
  logic signed [STATE_W-1:0]  integrator_two [0:SLOTS-1];
  logic signed [SAMPLE_W-1:0] drive_memory [0:CHANNELS-1];

  logic [CW-1:0]             ch;
  logic                      stage;
  logic signed [STATE_W-1:0] x;
  logic signed [STATE_W-1:0] ic1;
  logic signed [STATE_W-1:0] ic2;
  logic signed [STATE_W-1:0] v3;
  logic signed [STATE_W-1:0] band;
  logic signed [STATE_W-1:0] low;
  logic signed [ACC_W-1:0]   acc;
  logic [MAG_W-1:0]          mag;
  logic                      neg;
  logic [ROM_W-1:0]          tbase;
  logic                      tfull;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [ROM_W-1:0] lk_base;
  logic [ROM_W-1:0] lk_slope;
  logic [25:0]      lk_frac;
  logic             lk_full;

  logic              in_accept;
  logic              out_valid;
  logic signed [SAMPLE_W-1:0] out_word;
  logic [2:0]        chr_eff;
  logic              drive;
  logic              two_stage;
  logic [CW:0]       slot;
  logic [CW-1:0]     ch_in;

  logic signed [39:0]        rs22;
  logic signed [ACC_W-1:0]   drv_sum;
  logic signed [MAG_W:0]     arg;
  logic signed [ROM_W:0]     tval;
  logic signed [STATE_W-1:0] high;
  logic signed [STATE_W-1:0] ic1_new;
  logic signed [STATE_W-1:0] ic2_new;
  logic signed [STATE_W-1:0] tap;

  assign chr_eff   = (character > CHR_STRONG) ? CHR_CLEAN1 : character;
  assign drive     = (chr_eff == CHR_MILD) || (chr_eff == CHR_STRONG);
  assign two_stage = steep_slope || (chr_eff == CHR_TWO);
  assign slot      = {ch, stage};
  assign ch_in     = (32'(din.chan) < CHANNELS) ? CW'(din.chan) : '0;

  assign in_accept  = din.valid && din.ready;
  assign din.ready  = (state == ST_IDLE) && (!out_valid || dout.ready);
  assign dout.valid = out_valid;
  assign dout.sample_out = out_word;
  assign cfg.ready  = 1'b1;

  svf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  svf_tanh #(
    .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
  ) u_tanh (
    .pos   (prod[POS_W+1:2]),
    .base  (lk_base),
    .slope (lk_slope),
    .frac  (lk_frac),
    .full  (lk_full)
  );

  // Datapath arithmetic on the registered product.
  always_comb begin
    rs22    = 40'((prod + PROD_W'(64'sd2097152)) >>> 22);
    drv_sum = acc - ACC_W'(prod);
    arg     = (MAG_W+1)'((drv_sum + ACC_W'(32768)) >>> 16);
    tval    = tfull ? $signed({1'b0, Q26_ONE})
                    : $signed({1'b0, tbase + ROM_W'(prod >>> 26)});
    high    = sat32(48'(x) - 48'(rs22) - 48'(low));
    ic1_new = sat32((48'(band) <<< 1) - 48'(ic1));
    ic2_new = sat32((48'(low) <<< 1) - 48'(ic2));
    unique case (response)
      RESP_BAND: tap = band;
      RESP_HIGH: tap = high;
      default:   tap = low;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_accept && enable) state_next = ST_START;
      ST_START: state_next = drive ? ST_DRV1 : ST_V3;
      ST_DRV1:  state_next = ST_DRV2;
      ST_DRV2:  state_next = ST_DRV3;
      ST_DRV3:  state_next = ST_DRV4;
      ST_DRV4:  state_next = ST_DRV5;
      ST_DRV5:  state_next = ST_V3;
      ST_V3:    state_next = ST_F1;
      ST_F1:    state_next = ST_F2;
      ST_F2:    state_next = ST_F3;
      ST_F3:    state_next = ST_F4;
      ST_F4:    state_next = ST_F5;
      ST_F5:    state_next = ST_WB;
      ST_WB:    state_next = (!stage && two_stage) ? ST_START : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_DRV1: begin
        mul_a = MUL_A_W'(x);
        mul_b = MUL_B_W'((chr_eff == CHR_MILD) ? GAIN_X_MILD : GAIN_X_STRONG);
      end
      ST_DRV2: begin
        mul_a = MUL_A_W'(drive_memory[ch]) <<< 3;
        mul_b = MUL_B_W'((chr_eff == CHR_MILD) ? GAIN_D_MILD : GAIN_D_STRONG);
      end
      ST_DRV4: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(TANH_TABLE_SIZE);
      end
      ST_DRV5: begin
        mul_a = MUL_A_W'(lk_slope);
        mul_b = MUL_B_W'(lk_frac);
      end
      ST_F1: begin
        mul_a = MUL_A_W'(ic1);
        mul_b = MUL_B_W'(gain_a1);
      end
      ST_F2: begin
        mul_a = MUL_A_W'(v3);
        mul_b = MUL_B_W'(gain_a2);
      end
      ST_F3: begin
        mul_a = MUL_A_W'(ic1);
        mul_b = MUL_B_W'(gain_a2);
      end
      ST_F4: begin
        mul_a = MUL_A_W'(v3);
        mul_b = MUL_B_W'(gain_a3);
      end
      ST_F5: begin
        mul_a = MUL_A_W'(band);
        mul_b = MUL_B_W'(damping_coef);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The product of the operands chosen in one state is used in the following state.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_accept) begin
        x     <= STATE_W'(din.sample_in) <<< 3;
        ch    <= ch_in;
        stage <= 1'b0;
      end
      ST_START: begin
        ic1 <= integrator_one[slot];
        ic2 <= integrator_two[slot];
      end
      ST_DRV2: acc <= ACC_W'(prod);
      ST_DRV3: begin
        neg <= arg[MAG_W];
        mag <= arg[MAG_W] ? MAG_W'(-arg) : arg[MAG_W-1:0];
      end
      ST_DRV5: begin
        tbase <= lk_base;
        tfull <= lk_full;
      end
      ST_V3: begin
        if (drive) begin
          x  <= neg ? -STATE_W'(tval) : STATE_W'(tval);
          v3 <= sat32(48'(neg ? -STATE_W'(tval) : STATE_W'(tval)) - 48'(ic2));
        end else begin
          v3 <= sat32(48'(x) - 48'(ic2));
        end
      end
      ST_F2: acc <= ACC_W'(rs22);
      ST_F3: band <= sat32(48'(acc) + 48'(rs22));
      ST_F4: acc <= ACC_W'(ic2) + ACC_W'(rs22);
      ST_F5: low <= sat32(48'(acc) + 48'(rs22));
      // The first stage's tap feeds the second stage unchanged.
      ST_WB: if (!stage && two_stage) begin
        x     <= tap;
        stage <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state, integrators, drive memory, configuration and the output register.
  logic finish;
  assign finish = (state == ST_WB) && !(!stage && two_stage);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      character    <= CHR_CLEAN0;
      response     <= RESP_LOW;
      steep_slope  <= 1'b0;
      damping_coef <= 24'h800000;
      gain_a1      <= 24'h400000;
      gain_a2      <= '0;
      gain_a3      <= '0;
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        integrator_one[i] <= '0;
        integrator_two[i] <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        drive_memory[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_ENABLE:    enable       <= cfg.data[0];
          REG_CHARACTER: character    <= cfg.data[2:0];
          REG_RESPONSE:  response     <= cfg.data[1:0];
          REG_STEEP:     steep_slope  <= cfg.data[0];
          REG_DAMPING:   damping_coef <= cfg.data;
          REG_GAIN_A1:   gain_a1      <= cfg.data;
          REG_GAIN_A2:   gain_a2      <= cfg.data;
          REG_GAIN_A3:   gain_a3      <= cfg.data;
          default: begin
          end
        endcase
      end
      if ((in_accept && !enable) || finish) begin
        out_valid <= 1'b1;
        out_word  <= finish ? to_q123(tap) : din.sample_in;
      end else if (out_valid && dout.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_WB) begin
        integrator_one[slot] <= ic1_new;
        integrator_two[slot] <= ic2_new;
        if (drive) drive_memory[ch] <= to_q123(tap);
      end
    end
  end

endmodule

// File: verif/multimode_svf_filter_tb.sv
// Self-checking testbench of the multimode state-variable filter: random and directed samples
// across many register settings, checked against a fixed-point predictor held in a scoreboard.
// Depends on svf_pkg, the svf_if interfaces and the multimode_svf_filter top level.
`timescale 1ns / 1ps
module multimode_svf_filter_tb;
  import svf_pkg::*;

  localparam int NUM_CH   = 2;
  localparam int TBL_N    = 64;
  localparam longint ONE26 = 64'sd1 <<< 26;
  localparam longint ONE30 = 64'sd1 <<< 30;
  localparam longint INV_E = 64'sd395007542;

  class svf_scoreboard;
    bit                enable;
    logic [2:0]        chr_reg;
    logic [1:0]        resp_reg;
    bit                steep;
    longint            k_c, a1_c, a2_c, a3_c;
    int                ic1 [NUM_CH*2];
    int                ic2 [NUM_CH*2];
    int                drv [NUM_CH];
    longint            tanh_tbl [TBL_N+1];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int                mismatches;

    function void reset_state();
      longint y, n, f, sum, t;
      enable = 0; chr_reg = CHR_CLEAN0; resp_reg = RESP_LOW; steep = 0;
      k_c = 64'h800000; a1_c = 64'h400000; a2_c = 0; a3_c = 0;
      foreach (ic1[i]) begin
        ic1[i] = 0;
        ic2[i] = 0;
      end
      foreach (drv[i]) drv[i] = 0;
      mismatches = 0;
      // Table entry i is tanh(4i/N) = (1-z)/(1+z) with z = exp(-8i/N) in Q30.
      for (int i = 0; i <= TBL_N; i++) begin
        y = ((64'sd8 * i) <<< 30) / TBL_N;
        n = y >>> 30;
        f = y & (ONE30 - 1);
        sum = ONE30;
        t = ONE30;
        for (int j = 1; j <= 20; j++) begin
          t = (t * f) / (longint'(j) <<< 30);
          sum = (j & 1) ? sum - t : sum + t;
        end
        for (longint j = 0; j < n; j++) sum = (sum * INV_E) >>> 30;
        tanh_tbl[i] = ((ONE30 - sum) <<< 26) / (ONE30 + sum);
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [COEF_W-1:0] val);
      case (idx)
        REG_ENABLE:    enable = val[0];
        REG_CHARACTER: chr_reg = val[2:0];
        REG_RESPONSE:  resp_reg = val[1:0];
        REG_STEEP:     steep = val[0];
        REG_DAMPING:   k_c = longint'(val);
        REG_GAIN_A1:   a1_c = longint'(val);
        REG_GAIN_A2:   a2_c = longint'(val);
        REG_GAIN_A3:   a3_c = longint'(val);
        default: ;
      endcase
    endfunction

    // Floor of (v + half) / 2^n, i.e. round to nearest with ties upward.
    function longint round_sh(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint q26_to_q23(longint v);
      longint r;
      r = round_sh(v, 3);
      if (r > 64'sd8388607) return 64'sd8388607;
      if (r < -64'sd8388608) return -64'sd8388608;
      return r;
    endfunction

    function longint coef_prod(longint c, longint v);
      return round_sh(c * v, 22);
    endfunction

    function longint soft_clip(longint arg);
      bit     neg;
      longint m, p, idx, lo, diff, r;
      neg = arg < 0;
      m = neg ? -arg : arg;
      if (m > (64'sd1 <<< 40)) m = 64'sd1 <<< 40;
      p = (m * TBL_N) >>> 2;
      idx = p >>> 26;
      if (idx >= TBL_N) begin
        r = ONE26;
      end else begin
        lo = tanh_tbl[idx];
        diff = tanh_tbl[idx + 1] - lo;
        if (diff < 0) diff = 0;
        r = lo + ((diff * (p & (ONE26 - 1))) >>> 26);
      end
      return neg ? -r : r;
    endfunction

    function character_t eff_character();
      return (chr_reg > CHR_STRONG) ? CHR_CLEAN1 : character_t'(chr_reg);
    endfunction

    function longint filter_stage(longint x_in, int ch, int st);
      character_t chr;
      int     slot;
      longint x, gx, gd, s1, s2, v3, band, low, high, tap;
      chr = eff_character();
      slot = ch * 2 + st;
      x = x_in;
      if (chr == CHR_MILD || chr == CHR_STRONG) begin
        gx = (chr == CHR_MILD) ? longint'(GAIN_X_MILD) : longint'(GAIN_X_STRONG);
        gd = (chr == CHR_MILD) ? longint'(GAIN_D_MILD) : longint'(GAIN_D_STRONG);
        x = soft_clip(round_sh(gx * x - gd * (longint'(drv[ch]) * 8), 16));
      end
      s1 = ic1[slot];
      s2 = ic2[slot];
      v3 = clip32(x - s2);
      band = clip32(coef_prod(a1_c, s1) + coef_prod(a2_c, v3));
      low = clip32(s2 + coef_prod(a2_c, s1) + coef_prod(a3_c, v3));
      high = clip32(x - coef_prod(k_c, band) - low);
      ic1[slot] = int'(clip32(2 * band - s1));
      ic2[slot] = int'(clip32(2 * low - s2));
      tap = (resp_reg == RESP_BAND) ? band : ((resp_reg == RESP_HIGH) ? high : low);
      if (chr == CHR_MILD || chr == CHR_STRONG) drv[ch] = int'(q26_to_q23(tap));
      return tap;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic ch);
      longint y;
      if (!enable) begin
        expected_samples.push_back(s);
        return;
      end
      y = filter_stage(longint'(s) * 8, int'(ch), 0);
      if (steep || eff_character() == CHR_TWO) y = filter_stage(y, int'(ch), 1);
      expected_samples.push_back(q26_to_q23(y));
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output word %0d", got);
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: sample_out expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  svf_in_if  din ();
  svf_out_if dout ();
  svf_cfg_if cfg ();

  multimode_svf_filter DUT (.clk(clk), .rst(rst), .din(din), .dout(dout), .cfg(cfg));

  svf_scoreboard sb = new();
  int stall_mode = 0;

  initial begin
    din.valid = 0; din.sample_in = '0; din.chan = 0;
    dout.ready = 0;
    cfg.valid = 0; cfg.index = '0; cfg.data = '0;
  end

  always @(posedge clk) begin
    if (!rst && din.valid && din.ready) sb.note_sample(din.sample_in, din.chan);
    if (!rst && dout.valid && dout.ready) sb.check_sample(dout.sample_out);
  end

  // The receiver switches between always ready, random stalls and heavy random stalls.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: dout.ready <= 1'b1;
      1: dout.ready <= ($urandom_range(0, 3) != 0);
      default: dout.ready <= ($urandom_range(0, 15) < 4);
    endcase
  end

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic ch);
    @(negedge clk);
    din.valid = 1;
    din.sample_in = s;
    din.chan = ch;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg.valid = 1;
    cfg.index = idx;
    cfg.data = val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic drain_filter();
    @(negedge clk);
    din.valid = 0;
    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic apply_setting(logic en, logic [2:0] chr, logic [1:0] resp, logic stp,
                               logic [23:0] k, logic [23:0] a1, logic [23:0] a2,
                               logic [23:0] a3);
    drain_filter();
    write_reg(REG_ENABLE, {23'd0, en});
    write_reg(REG_CHARACTER, {21'd0, chr});
    write_reg(REG_RESPONSE, {22'd0, resp});
    write_reg(REG_STEEP, {23'd0, stp});
    write_reg(REG_DAMPING, k);
    write_reg(REG_GAIN_A1, a1);
    write_reg(REG_GAIN_A2, a2);
    write_reg(REG_GAIN_A3, a3);
  endtask

  function automatic logic [23:0] pick_coef(int lo, int hi);
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_burst(int count);
    int left;
    left = count;
    while (left > 0) begin
      for (int i = $urandom_range(1, 12); i > 0 && left > 0; i--) begin
        send_sample(pick_sample(), 1'($urandom));
        left--;
      end
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        din.valid = 0;
        repeat ($urandom_range(0, 25)) @(negedge clk);
      end
    end
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] edge_vals [4];
    edge_vals = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh000001};
    sb.reset_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: bypass at reset values, then each character and tap on the extremes.
    foreach (edge_vals[i]) send_sample(edge_vals[i], 1'(i));
    for (int c = 0; c <= 5; c++) begin
      apply_setting(1, 3'(c), 2'(c % 4), 1'(c == 1), 24'h800000, 24'h3A0000,
                    24'h0C0000, 24'h020000);
      foreach (edge_vals[i]) send_sample(edge_vals[i], 1'(i >> 1));
    end
    apply_setting(1, 3'd7, 2'd3, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    foreach (edge_vals[i]) send_sample(edge_vals[i], 1'(i));

    for (int ph = 0; ph < 15; ph++) begin
      apply_setting(1'($urandom_range(0, 7) != 0), 3'($urandom_range(0, 7)),
                    2'($urandom_range(0, 3)), 1'($urandom), pick_coef(24'h100000, 24'h800000),
                    pick_coef(24'h200000, 24'h400000), pick_coef(24'h010000, 24'h200000),
                    pick_coef(24'h001000, 24'h100000));
      run_burst(130);
    end

    drain_filter();
    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: multimode_svf_filter.f
src/svf_pkg.sv
src/svf_if.sv
src/svf_mul.sv
src/svf_tanh.sv
src/multimode_svf_filter.sv
verif/multimode_svf_filter_tb.sv
